// ----- src/trng_hpf_pkg.sv -----
// ----------------------------------------------------------------------------
// trng_hpf_pkg
// Shared types and constants of the random source health filter.
// ----------------------------------------------------------------------------
package trng_hpf_pkg;

    localparam int unsigned HANG_BITS  = 8;
    localparam int unsigned POLL_BITS  = 16;
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned CFG_DATA_BITS = 16;

    localparam logic [HANG_BITS-1:0] HANG_LIMIT_RST  = 8'd100;
    localparam logic [POLL_BITS-1:0] POLL_BUDGET_RST = 16'd1000;
    localparam logic [POLL_BITS-1:0] POLL_ENDED      = 16'hFFFF;

    localparam logic [CFG_IDX_BITS-1:0] REG_HANG_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POLL_BUDGET = 2'd1;

    typedef enum logic [1:0] {
        CMD_BLOCKING = 2'd0,
        CMD_BOUNDED  = 2'd1,
        CMD_START    = 2'd2,
        CMD_UNUSED   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic enabled;
        logic int_err;
        logic now_err;
        logic ready;
    } t_poll;

    typedef struct packed {
        logic word_valid;
        logic draw_failed;
        logic clear_error_flags;
        logic reset_request;
        logic error_seen;
    } t_flags;

endpackage

// ----- src/trng_hpf_qualify.sv -----
// ----------------------------------------------------------------------------
// trng_hpf_qualify
// Health state and per-poll qualification: discard, repeat test, hang count,
// bounded draw count and the sticky error latch.
// ----------------------------------------------------------------------------
module trng_hpf_qualify #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_fire,
    input  trng_hpf_pkg::t_poll                  i_poll,
    input  logic [WORD_BITS-1:0]                 i_word,
    input  logic [trng_hpf_pkg::HANG_BITS-1:0]   i_hang_limit,
    input  logic [trng_hpf_pkg::POLL_BITS-1:0]   i_poll_budget,
    output trng_hpf_pkg::t_flags                 o_flags,
    output logic [WORD_BITS-1:0]                 o_word
);
    import trng_hpf_pkg::*;

    logic [WORD_BITS-1:0] r_prev_word, n_prev_word;
    logic                 r_discard_pending, n_discard_pending;
    logic                 r_error_latch, n_error_latch;
    logic [HANG_BITS-1:0] r_hang_count, n_hang_count;
    logic [POLL_BITS-1:0] r_poll_count, n_poll_count;

    logic [HANG_BITS:0]   hang_next;
    logic [POLL_BITS-1:0] poll_base;
    logic [POLL_BITS-1:0] poll_inc;
    logic                 fresh;

    always_comb begin
        n_prev_word       = r_prev_word;
        n_discard_pending = r_discard_pending;
        n_error_latch     = r_error_latch;
        n_hang_count      = r_hang_count;
        n_poll_count      = r_poll_count;
        o_flags           = '0;
        o_word            = '0;
        hang_next         = {1'b0, r_hang_count} + {{HANG_BITS{1'b0}}, 1'b1};
        fresh             = (i_word != r_prev_word);
        poll_base         = (i_poll.cmd == CMD_START) ? '0 : r_poll_count;
        poll_inc          = poll_base + {{(POLL_BITS-1){1'b0}}, 1'b1};

        unique case (i_poll.cmd)
            CMD_BLOCKING: begin
                if (!i_poll.int_err) begin
                    if (i_poll.ready) begin
                        if (r_discard_pending) begin
                            n_discard_pending = 1'b0;
                        end else if (fresh) begin
                            n_prev_word        = i_word;
                            o_flags.word_valid = 1'b1;
                            o_word             = i_word;
                            n_hang_count       = '0;
                        end
                    end
                end else if (!i_poll.now_err) begin
                    n_error_latch             = 1'b1;
                    o_flags.clear_error_flags = 1'b1;
                end else if (hang_next >= {1'b0, i_hang_limit}) begin
                    n_error_latch         = 1'b1;
                    n_hang_count          = '0;
                    n_discard_pending     = 1'b1;
                    o_flags.reset_request = 1'b1;
                end else begin
                    n_hang_count = hang_next[HANG_BITS-1:0];
                end
            end
            CMD_BOUNDED, CMD_START: begin
                n_hang_count = '0;
                n_poll_count = poll_base;
                if (poll_base >= i_poll_budget) begin
                    o_flags.draw_failed = 1'b1;
                end else begin
                    n_poll_count = poll_inc;
                    if (!i_poll.enabled) begin
                        o_flags.draw_failed = 1'b1;
                    end else if (i_poll.int_err || i_poll.now_err) begin
                        n_error_latch       = 1'b1;
                        o_flags.draw_failed = 1'b1;
                    end else if (i_poll.ready) begin
                        if (r_discard_pending) begin
                            n_discard_pending = 1'b0;
                        end else if (fresh) begin
                            n_prev_word        = i_word;
                            o_flags.word_valid = 1'b1;
                            o_word             = i_word;
                        end
                    end
                    if (!o_flags.word_valid && (poll_inc >= i_poll_budget)) begin
                        o_flags.draw_failed = 1'b1;
                    end
                    if (o_flags.word_valid || o_flags.draw_failed) begin
                        n_poll_count = POLL_ENDED;
                    end
                end
            end
            CMD_UNUSED: begin
            end
            default: begin
            end
        endcase
        o_flags.error_seen = n_error_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_word       <= '0;
            r_discard_pending <= 1'b0;
            r_error_latch     <= 1'b0;
            r_hang_count      <= '0;
            r_poll_count      <= '0;
        end else if (i_fire) begin
            r_prev_word       <= n_prev_word;
            r_discard_pending <= n_discard_pending;
            r_error_latch     <= n_error_latch;
            r_hang_count      <= n_hang_count;
            r_poll_count      <= n_poll_count;
        end
    end

    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error_latch |=> r_error_latch)
        else $error("error latch dropped without reset");

    a_reset_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_flags.reset_request) |=> (r_discard_pending && r_hang_count == '0))
        else $error("reset request did not re-arm discard");

    a_word_or_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |-> !(o_flags.word_valid && o_flags.draw_failed))
        else $error("word delivered on a failed draw");

    a_clear_blocking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (o_flags.clear_error_flags || o_flags.reset_request))
            |-> (i_poll.cmd == CMD_BLOCKING))
        else $error("flag clear or reset on a non-blocking poll");

    a_repeat_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_flags.word_valid) |=> (r_prev_word == $past(i_word)))
        else $error("accepted word not remembered");

endmodule

// ----- src/trng_health_poll_filter.sv -----
// ----------------------------------------------------------------------------
// trng_health_poll_filter
// Qualifies status polls of a true random source and delivers tested words.
// ----------------------------------------------------------------------------
// One input beat is one status poll (command, enable, error bits, data).
// Each poll yields exactly one output beat with the word, failure and request
// flags, and the error latch value after that poll.
// A poll passes through an input register, then the qualify logic into the
// output register. One poll per cycle is sustained unless the receiver stalls;
// the repeat test and all counters update as a poll leaves the input register.
// A poll is taken while a finished beat still waits on the output, the input
// register holding it until the output frees up; when the receiver stalls
// both registers fill and ready drops.
// The config channel writes hang_limit (index 0) and poll_budget (index 1) and
// is always ready; other indexes are ignored. Write it only while no poll is in
// flight.
// Reset loads hang_limit 100 and poll_budget 1000 and clears the remembered
// word, discard, hang and poll counts and the sticky error latch.
// ----------------------------------------------------------------------------
module trng_health_poll_filter #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [1:0]                               i_command,
    input  logic                                     i_source_enabled,
    input  logic                                     i_seed_error_int,
    input  logic                                     i_clock_error_int,
    input  logic                                     i_seed_error_now,
    input  logic                                     i_clock_error_now,
    input  logic                                     i_data_ready,
    input  logic [WORD_BITS-1:0]                     i_data_word,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic                                     o_word_valid,
    output logic [WORD_BITS-1:0]                     o_random_word,
    output logic                                     o_draw_failed,
    output logic                                     o_clear_error_flags,
    output logic                                     o_reset_request,
    output logic                                     o_error_seen,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [trng_hpf_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [trng_hpf_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import trng_hpf_pkg::*;

    logic                 r_in_valid;
    t_poll                r_poll;
    logic [WORD_BITS-1:0] r_in_word;
    logic                 r_out_valid;
    t_flags               r_flags;
    logic [WORD_BITS-1:0] r_out_word;
    logic [HANG_BITS-1:0] r_hang_limit;
    logic [POLL_BITS-1:0] r_poll_budget;

    logic                 out_free;
    logic                 fire;
    logic                 in_take;
    t_flags               q_flags;
    logic [WORD_BITS-1:0] q_word;

    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // poll and result payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_poll.cmd     <= t_cmd'(i_command);
            r_poll.enabled <= i_source_enabled;
            r_poll.int_err <= i_seed_error_int | i_clock_error_int;
            r_poll.now_err <= i_seed_error_now | i_clock_error_now;
            r_poll.ready   <= i_data_ready;
            r_in_word      <= i_data_word;
        end
        if (fire) begin
            r_flags    <= q_flags;
            r_out_word <= q_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hang_limit  <= HANG_LIMIT_RST;
            r_poll_budget <= POLL_BUDGET_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_HANG_LIMIT) begin
                r_hang_limit <= i_cfg_data[HANG_BITS-1:0];
            end else if (i_cfg_index == REG_POLL_BUDGET) begin
                r_poll_budget <= i_cfg_data[POLL_BITS-1:0];
            end
        end
    end

    trng_hpf_qualify #(
        .WORD_BITS (WORD_BITS)
    ) u_qualify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_poll        (r_poll),
        .i_word        (r_in_word),
        .i_hang_limit  (r_hang_limit),
        .i_poll_budget (r_poll_budget),
        .o_flags       (q_flags),
        .o_word        (q_word)
    );

    assign o_out_valid         = r_out_valid;
    assign o_word_valid        = r_flags.word_valid;
    assign o_random_word       = r_out_word;
    assign o_draw_failed       = r_flags.draw_failed;
    assign o_clear_error_flags = r_flags.clear_error_flags;
    assign o_reset_request     = r_flags.reset_request;
    assign o_error_seen        = r_flags.error_seen;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the random source health filter. Status polls are driven
// through the valid/ready input channel, and a per-poll model in the bench
// predicts each output beat: the repeat test, discard after reset, the sticky
// error latch, flag clear and reset requests, hang counting and the poll
// budget of bounded draws. Output beats are compared field by field in order.
// Directed polls come first, then random sequences under several register
// settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb;
    import trng_hpf_pkg::*;

    localparam int unsigned WORD_BITS = 32;

    // error bit masks, {seed_int, clock_int, seed_now, clock_now}
    localparam logic [3:0] ERR_NONE      = 4'b0000;
    localparam logic [3:0] ERR_SEED_INT  = 4'b1000;
    localparam logic [3:0] ERR_CLOCK_INT = 4'b0100;
    localparam logic [3:0] ERR_SEED_NOW  = 4'b0010;
    localparam logic [3:0] ERR_CLOCK_NOW = 4'b0001;
    localparam logic [3:0] ERR_ALL       = 4'b1111;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

    typedef struct {
        t_cmd                 cmd;
        logic                 enabled;
        logic                 seed_int;
        logic                 clock_int;
        logic                 seed_now;
        logic                 clock_now;
        logic                 ready;
        logic [WORD_BITS-1:0] word;
    } t_tb_poll;

    typedef struct {
        logic                 word_valid;
        logic [WORD_BITS-1:0] random_word;
        logic                 draw_failed;
        logic                 clear_flags;
        logic                 reset_req;
        logic                 error_seen;
    } t_verdict;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [1:0]                 i_command;
    logic                       i_source_enabled;
    logic                       i_seed_error_int;
    logic                       i_clock_error_int;
    logic                       i_seed_error_now;
    logic                       i_clock_error_now;
    logic                       i_data_ready;
    logic [WORD_BITS-1:0]       i_data_word;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic                       o_word_valid;
    logic [WORD_BITS-1:0]       o_random_word;
    logic                       o_draw_failed;
    logic                       o_clear_error_flags;
    logic                       o_reset_request;
    logic                       o_error_seen;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]    i_cfg_index;
    logic [CFG_DATA_BITS-1:0]   i_cfg_data;

    trng_health_poll_filter #(
        .WORD_BITS(WORD_BITS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_source_enabled   (i_source_enabled),
        .i_seed_error_int   (i_seed_error_int),
        .i_clock_error_int  (i_clock_error_int),
        .i_seed_error_now   (i_seed_error_now),
        .i_clock_error_now  (i_clock_error_now),
        .i_data_ready       (i_data_ready),
        .i_data_word        (i_data_word),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_word_valid       (o_word_valid),
        .o_random_word      (o_random_word),
        .o_draw_failed      (o_draw_failed),
        .o_clear_error_flags(o_clear_error_flags),
        .o_reset_request    (o_reset_request),
        .o_error_seen       (o_error_seen),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // filter model state
    logic [HANG_BITS-1:0] hang_limit_cfg;
    logic [POLL_BITS-1:0] poll_budget_cfg;
    logic [WORD_BITS-1:0] last_word;
    logic                 discard_armed;
    logic                 error_latched;
    logic [HANG_BITS-1:0] hang_cnt;
    logic [POLL_BITS-1:0] poll_cnt;

    t_verdict             verdict_q[$];
    logic [WORD_BITS-1:0] last_sent;
    int                   send_idle_pct;
    int                   stall_pct;
    int                   mismatches;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("trng_health_poll_filter test failed");
        $finish;
    end

    function automatic t_verdict qualify_poll(t_tb_poll p);
        t_verdict v;
        logic     int_err;
        logic     now_err;
        logic [HANG_BITS:0] next_hang;
        v = '{default: '0};
        int_err = p.seed_int | p.clock_int;
        now_err = p.seed_now | p.clock_now;
        case (p.cmd)
            CMD_BLOCKING: begin
                if (!int_err) begin
                    if (p.ready) begin
                        if (discard_armed) begin
                            discard_armed = 1'b0;
                        end else if (p.word != last_word) begin
                            last_word     = p.word;
                            v.word_valid  = 1'b1;
                            v.random_word = p.word;
                            hang_cnt      = '0;
                        end
                    end
                end else if (!now_err) begin
                    error_latched = 1'b1;
                    v.clear_flags = 1'b1;
                end else begin
                    next_hang = {1'b0, hang_cnt} + (HANG_BITS+1)'(1);
                    if (next_hang >= {1'b0, hang_limit_cfg}) begin
                        error_latched = 1'b1;
                        hang_cnt      = '0;
                        discard_armed = 1'b1;
                        v.reset_req   = 1'b1;
                    end else begin
                        hang_cnt = next_hang[HANG_BITS-1:0];
                    end
                end
            end
            CMD_BOUNDED, CMD_START: begin
                hang_cnt = '0;
                if (p.cmd == CMD_START) poll_cnt = '0;
                if (poll_cnt >= poll_budget_cfg) begin
                    v.draw_failed = 1'b1;
                end else begin
                    poll_cnt = poll_cnt + POLL_BITS'(1);
                    if (!p.enabled) begin
                        v.draw_failed = 1'b1;
                    end else if (int_err || now_err) begin
                        error_latched = 1'b1;
                        v.draw_failed = 1'b1;
                    end else if (p.ready) begin
                        if (discard_armed) begin
                            discard_armed = 1'b0;
                        end else if (p.word != last_word) begin
                            last_word     = p.word;
                            v.word_valid  = 1'b1;
                            v.random_word = p.word;
                        end
                    end
                    if (!v.word_valid && poll_cnt >= poll_budget_cfg) v.draw_failed = 1'b1;
                    if (v.word_valid || v.draw_failed) poll_cnt = POLL_ENDED;
                end
            end
            default: ;
        endcase
        v.error_seen = error_latched;
        return v;
    endfunction

    function automatic t_tb_poll poll_of(t_cmd cmd, logic [3:0] errs, logic enabled,
                                         logic ready, logic [WORD_BITS-1:0] word);
        t_tb_poll p;
        p.cmd       = cmd;
        p.enabled   = enabled;
        p.seed_int  = errs[3];
        p.clock_int = errs[2];
        p.seed_now  = errs[1];
        p.clock_now = errs[0];
        p.ready     = ready;
        p.word      = word;
        return p;
    endfunction

    function automatic t_tb_poll random_poll(t_cmd cmd, int err_pct);
        t_tb_poll p;
        p.cmd       = cmd;
        p.enabled   = $urandom_range(99) >= 6;
        p.seed_int  = $urandom_range(99) < err_pct;
        p.clock_int = $urandom_range(99) < err_pct;
        p.seed_now  = $urandom_range(99) < err_pct;
        p.clock_now = $urandom_range(99) < err_pct;
        p.ready     = $urandom_range(99) < 75;
        case ($urandom_range(7))
            0, 1:    p.word = last_sent;
            2:       p.word = '0;
            3:       p.word = '1;
            default: p.word = $urandom;
        endcase
        return p;
    endfunction

    function automatic t_tb_poll hung_poll();
        t_tb_poll p;
        p = random_poll(CMD_BLOCKING, 30);
        if ($urandom_range(1)) p.seed_int = 1'b1;
        else p.clock_int = 1'b1;
        if ($urandom_range(1)) p.seed_now = 1'b1;
        else p.clock_now = 1'b1;
        return p;
    endfunction

    task automatic report_mismatch(string field, logic [WORD_BITS-1:0] got,
                                   logic [WORD_BITS-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic send_poll(t_tb_poll p);
        t_verdict v;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_command         = p.cmd;
        i_source_enabled  = p.enabled;
        i_seed_error_int  = p.seed_int;
        i_clock_error_int = p.clock_int;
        i_seed_error_now  = p.seed_now;
        i_clock_error_now = p.clock_now;
        i_data_ready      = p.ready;
        i_data_word       = p.word;
        do @(posedge i_clk); while (!o_in_ready);
        last_sent = p.word;
        v = qualify_poll(p);
        verdict_q.push_back(v);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_HANG_LIMIT) hang_limit_cfg = data[HANG_BITS-1:0];
        else if (idx == REG_POLL_BUDGET) poll_budget_cfg = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // checks every output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("out_valid, no poll outstanding",
                                WORD_BITS'(o_out_valid), '0);
            end else begin
                exp_v = verdict_q.pop_front();
                if (o_word_valid !== exp_v.word_valid)
                    report_mismatch("word_valid", WORD_BITS'(o_word_valid),
                                    WORD_BITS'(exp_v.word_valid));
                if (o_random_word !== exp_v.random_word)
                    report_mismatch("random_word", o_random_word, exp_v.random_word);
                if (o_draw_failed !== exp_v.draw_failed)
                    report_mismatch("draw_failed", WORD_BITS'(o_draw_failed),
                                    WORD_BITS'(exp_v.draw_failed));
                if (o_clear_error_flags !== exp_v.clear_flags)
                    report_mismatch("clear_error_flags", WORD_BITS'(o_clear_error_flags),
                                    WORD_BITS'(exp_v.clear_flags));
                if (o_reset_request !== exp_v.reset_req)
                    report_mismatch("reset_request", WORD_BITS'(o_reset_request),
                                    WORD_BITS'(exp_v.reset_req));
                if (o_error_seen !== exp_v.error_seen)
                    report_mismatch("error_seen", WORD_BITS'(o_error_seen),
                                    WORD_BITS'(exp_v.error_seen));
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready = $urandom_range(99) >= stall_pct;
    end

    task automatic test_word_filter();
        send_poll(poll_of(CMD_BOUNDED, ERR_NONE, 1'b1, 1'b1, 32'h0000_0001));
        send_poll(poll_of(CMD_BOUNDED, ERR_NONE, 1'b1, 1'b1, 32'h0000_0002));
        send_poll(poll_of(CMD_UNUSED, ERR_ALL, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_poll(poll_of(CMD_START, ERR_NONE, 1'b0, 1'b1, 32'h0000_0003));
        send_poll(poll_of(CMD_START, ERR_NONE, 1'b1, 1'b0, 32'h0000_0004));
        send_poll(poll_of(CMD_BOUNDED, ERR_NONE, 1'b1, 1'b1, 32'h0000_0001));
        send_poll(poll_of(CMD_BOUNDED, ERR_NONE, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_poll(poll_of(CMD_BLOCKING, ERR_NONE, 1'b0, 1'b1, 32'h0000_0000));
        send_poll(poll_of(CMD_BLOCKING, ERR_NONE, 1'b1, 1'b1, 32'h0000_0000));
        send_poll(poll_of(CMD_BLOCKING, ERR_SEED_NOW | ERR_CLOCK_NOW, 1'b1, 1'b1,
                          32'hA5A5_A5A5));
    endtask

    task automatic test_error_paths();
        repeat (2) send_poll(poll_of(CMD_BLOCKING, ERR_SEED_INT | ERR_CLOCK_NOW, 1'b1,
                                     1'b1, 32'h1111_1111));
        send_poll(poll_of(CMD_START, ERR_NONE, 1'b1, 1'b1, 32'h5A5A_5A5A));
        send_poll(poll_of(CMD_BLOCKING, ERR_SEED_INT, 1'b1, 1'b1, 32'h2222_2222));
        send_poll(poll_of(CMD_START, ERR_CLOCK_NOW, 1'b1, 1'b1, 32'h3333_3333));
        send_poll(poll_of(CMD_BLOCKING, ERR_CLOCK_INT | ERR_SEED_NOW, 1'b1, 1'b0,
                          32'h4444_4444));
    endtask

    task automatic test_hang_reset();
        cfg_write(REG_HANG_LIMIT, 16'd1);
        send_poll(poll_of(CMD_BLOCKING, ERR_CLOCK_INT | ERR_CLOCK_NOW, 1'b1, 1'b0, '0));
        send_poll(poll_of(CMD_BLOCKING, ERR_NONE, 1'b1, 1'b1, 32'h0000_1234));
        send_poll(poll_of(CMD_BLOCKING, ERR_NONE, 1'b1, 1'b1, 32'h0000_1234));
        // zero limit behaves as one
        cfg_write(REG_HANG_LIMIT, 16'd0);
        send_poll(poll_of(CMD_BLOCKING, ERR_SEED_INT | ERR_SEED_NOW, 1'b1, 1'b1, '1));
        send_poll(poll_of(CMD_START, ERR_NONE, 1'b1, 1'b1, 32'h0000_4321));
        send_poll(poll_of(CMD_BOUNDED, ERR_NONE, 1'b1, 1'b1, 32'h0000_4321));
        // bounded command restarts the hang count
        cfg_write(REG_HANG_LIMIT, 16'd3);
        repeat (2) send_poll(poll_of(CMD_BLOCKING, ERR_ALL, 1'b1, 1'b0, '0));
        send_poll(poll_of(CMD_START, ERR_NONE, 1'b1, 1'b0, '0));
        repeat (3) send_poll(poll_of(CMD_BLOCKING, ERR_ALL, 1'b1, 1'b0, '0));
    endtask

    task automatic test_poll_budget();
        cfg_write(REG_SPARE, '1);
        cfg_write(REG_POLL_BUDGET, 16'd0);
        send_poll(poll_of(CMD_START, ERR_NONE, 1'b1, 1'b1, 32'hDEAD_BEEF));
        cfg_write(REG_POLL_BUDGET, 16'd1);
        send_poll(poll_of(CMD_START, ERR_NONE, 1'b1, 1'b0, '0));
        cfg_write(REG_POLL_BUDGET, 16'd3);
        send_poll(poll_of(CMD_START, ERR_NONE, 1'b1, 1'b0, '0));
        repeat (3) send_poll(poll_of(CMD_BOUNDED, ERR_NONE, 1'b1, 1'b0, '0));
    endtask

    task automatic test_random_phase(int send_pct, int stall_pct_v,
                                     logic [HANG_BITS-1:0] hang,
                                     logic [POLL_BITS-1:0] maxp, int n);
        int sent;
        int pick;
        int len;
        int cap;
        cfg_write(REG_HANG_LIMIT, {8'h00, hang});
        cfg_write(REG_POLL_BUDGET, maxp);
        send_idle_pct = send_pct;
        stall_pct     = stall_pct_v;
        sent = 0;
        while (sent < n) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                len = $urandom_range(1, 8);
                repeat (len) send_poll(random_poll(CMD_BLOCKING, 3));
            end else if (pick < 75) begin
                cap = (poll_budget_cfg < 12) ? int'(poll_budget_cfg) + 1 : 12;
                len = $urandom_range(0, cap);
                send_poll(random_poll(CMD_START, 3));
                repeat (len) send_poll(random_poll(CMD_BOUNDED, 3));
                len = len + 1;
            end else if (pick < 88) begin
                cap = (hang_limit_cfg < 10) ? int'(hang_limit_cfg) + 1 : 10;
                len = $urandom_range(1, cap);
                repeat (len) send_poll(hung_poll());
            end else begin
                len = 1;
                send_poll(random_poll(t_cmd'($urandom_range(3)), 30));
            end
            sent = sent + len;
        end
    endtask

    initial begin
        mismatches        = 0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        last_sent         = '0;
        hang_limit_cfg    = HANG_LIMIT_RST;
        poll_budget_cfg   = POLL_BUDGET_RST;
        last_word         = '0;
        discard_armed     = 1'b0;
        error_latched     = 1'b0;
        hang_cnt          = '0;
        poll_cnt          = '0;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_out_ready       = 1'b1;
        i_command         = CMD_BLOCKING;
        i_source_enabled  = 1'b0;
        i_seed_error_int  = 1'b0;
        i_clock_error_int = 1'b0;
        i_seed_error_now  = 1'b0;
        i_clock_error_now = 1'b0;
        i_data_ready      = 1'b0;
        i_data_word       = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = REG_HANG_LIMIT;
        i_cfg_data        = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_word_filter();
        test_error_paths();
        test_hang_reset();
        test_poll_budget();
        test_random_phase(0, 0, 8'd4, 16'd6, 200);
        test_random_phase(84, 0, 8'd255, 16'd65535, 200);
        test_random_phase(0, 84, 8'd1, 16'd1, 200);
        test_random_phase(15, 15, 8'($urandom_range(0, 12)), 16'($urandom_range(0, 12)), 200);
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("trng_health_poll_filter test passed");
        end else begin
            $display("trng_health_poll_filter test failed");
        end
        $finish;
    end

endmodule
